/* src/xrr_pkg.sv */
// Shared types and constants for the ranged xorshift128+ generator.
package xrr_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CNT_W     = $clog2(WORD_W);

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] SEED_FIRST_RST  = WORD_W'(1);
    localparam logic [WORD_W-1:0] SEED_SECOND_RST = WORD_W'(2);

    localparam int unsigned SHIFT_A = 23;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 26;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

/* src/xorshift_ranged_random_top.sv */
// Ranged xorshift128+ generator: one-bit-per-cycle restoring modulo unit.
// For unequal bounds an input transfer starts 64 remainder steps in a single subtractor;
// ST_HOLD then adds the lower bound and loads the output register once the output is free.
// Equal bounds go straight to ST_HOLD. No new input is taken until the result is loaded.
// Reset (synchronous, active low) loads seeds 1 and 2 into the state and empties the output.
module xorshift_ranged_random_top
    import xrr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*WORD_W-1:0]    s_axis_tdata,   // lower_bound, upper_bound
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [WORD_W-1:0]      m_axis_tdata    // value
);

    t_state             r_state, n_state;
    logic [WORD_W-1:0]  r_seed_a, n_seed_a;
    logic [WORD_W-1:0]  r_seed_b, n_seed_b;
    logic [WORD_W-1:0]  r_s0, n_s0;
    logic [WORD_W-1:0]  r_s1, n_s1;
    logic [WORD_W-1:0]  r_dvd, n_dvd;
    logic [WORD_W-1:0]  r_rng, n_rng;
    logic [WORD_W-1:0]  r_rem, n_rem;
    logic [WORD_W-1:0]  r_low, n_low;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_out_data, n_out_data;

    logic [WORD_W-1:0]  lower, upper;
    logic [WORD_W-1:0]  x_mix, s1_new;
    logic [WORD_W:0]    shifted, diff;
    logic               in_xfer, cfg_xfer, out_free;

    assign lower = s_axis_tdata[WORD_W-1:0];
    assign upper = s_axis_tdata[2*WORD_W-1:WORD_W];

    assign x_mix  = r_s0 ^ (r_s0 << SHIFT_A);
    assign s1_new = x_mix ^ r_s1 ^ (x_mix >> SHIFT_B) ^ (r_s1 >> SHIFT_C);

    assign shifted = {r_rem, r_dvd[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_rng};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = i_cfg_valid && o_cfg_ready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_seed_a    = r_seed_a;
        n_seed_b    = r_seed_b;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_dvd       = r_dvd;
        n_rng       = r_rng;
        n_rem       = r_rem;
        n_low       = r_low;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_low = lower;
                    n_rem = '0;
                    n_cnt = '0;
                    if (lower == upper) begin
                        n_state = ST_HOLD;
                    end else begin
                        n_s0    = r_s1;
                        n_s1    = s1_new;
                        n_dvd   = s1_new + r_s1;
                        n_rng   = upper - lower;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
                n_dvd = {r_dvd[WORD_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rem + r_low;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_SEED_FIRST: begin
                    n_seed_a = i_cfg_data;
                    n_s0     = i_cfg_data;
                    n_s1     = r_seed_b;
                end
                CFG_SEED_SECOND: begin
                    n_seed_b = i_cfg_data;
                    n_s0     = r_seed_a;
                    n_s1     = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_seed_a    <= SEED_FIRST_RST;
            r_seed_b    <= SEED_SECOND_RST;
            r_s0        <= SEED_FIRST_RST;
            r_s1        <= SEED_SECOND_RST;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_seed_a    <= n_seed_a;
            r_seed_b    <= n_seed_b;
            r_s0        <= n_s0;
            r_s1        <= n_s1;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rng      <= n_rng;
        r_rem      <= n_rem;
        r_low      <= n_low;
        r_out_data <= n_out_data;
    end

endmodule

/* src/xrr_checker.sv */
// Port-level checker for the ranged xorshift128+ generator, bound to the top level.
module xrr_checker
    import xrr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [2*WORD_W-1:0]    s_axis_tdata,   // lower_bound, upper_bound
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [WORD_W-1:0]      m_axis_tdata    // value
);

    logic in_xfer;
    logic bounds_equal;

    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign bounds_equal = s_axis_tdata[WORD_W-1:0] == s_axis_tdata[2*WORD_W-1:WORD_W];

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

    a_equal_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && bounds_equal && !m_axis_tvalid |=> ##1
        m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata[WORD_W-1:0], 2)))
        else $error("equal bounds did not return the lower bound");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued without returning to idle");

endmodule

bind xorshift_ranged_random_top xrr_checker u_xrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/testbench.sv */
// Self-checking testbench for the ranged xorshift128+ generator.
`timescale 1ns / 1ps

module testbench;
    import xrr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 70;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 210;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = {CFG_IDX_W{1'b1}};

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*WORD_W-1:0]  s_axis_tdata = '0;   // lower_bound, upper_bound
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_W-1:0]    m_axis_tdata;        // value

    logic [WORD_W-1:0] seed_reg_a = SEED_FIRST_RST;
    logic [WORD_W-1:0] seed_reg_b = SEED_SECOND_RST;
    logic [WORD_W-1:0] gen_word_a = SEED_FIRST_RST;
    logic [WORD_W-1:0] gen_word_b = SEED_SECOND_RST;

    logic [WORD_W-1:0] value_queue[$];
    int                error_count = 0;
    int                quiet_cycles = 0;
    int                hold_off_len = 0;
    bit                tx_gaps = 1'b1;
    bit                rx_gaps = 1'b1;

    xorshift_ranged_random_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 100);
    endfunction

    // One xorshift128+ step on the mirrored state.
    function automatic logic [WORD_W-1:0] advance_generator();
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        x = gen_word_a;
        y = gen_word_b;
        gen_word_a = y;
        x = x ^ (x << SHIFT_A);
        gen_word_b = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
        return gen_word_b + y;
    endfunction

    function automatic logic [WORD_W-1:0] predict_value(logic [WORD_W-1:0] lo,
                                                        logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] span;
        if (lo == hi) return lo;
        span = hi - lo;
        return (advance_generator() % span) + lo;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_bounds(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        value_queue.push_back(predict_value(lo, hi));
    endtask

    // Drop valid, drain all results, then let the block go quiet.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (value_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SEED_FIRST) begin
            seed_reg_a = data;
        end else if (idx == CFG_SEED_SECOND) begin
            seed_reg_b = data;
        end else begin
            return;
        end
        gen_word_a = seed_reg_a;
        gen_word_b = seed_reg_b;
    endtask

    task automatic pick_bounds(output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] hi);
        int                r;
        int                s;
        logic [31:0]       t;
        logic [WORD_W-1:0] span;
        r  = $urandom_range(0, 99);
        lo = rand_word();
        if (r < 30) begin
            hi = rand_word();
        end else if (r < 55) begin
            hi = lo + WORD_W'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 16 : 65536));
        end else if (r < 65) begin
            hi = lo;
        end else if (r < 75) begin
            s  = $urandom_range(0, 2000) - 1000;
            t  = s;
            lo = {{32{t[31]}}, t};
            hi = lo + WORD_W'($urandom_range(1, 2000));
        end else if (r < 88) begin
            span = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            case ($urandom_range(0, 2))
                0: begin
                    span = span - 1;
                end
                2: begin
                    span = span + 1;
                end
                default: begin
                end
            endcase
            hi = lo + span;
        end else begin
            hi = lo - WORD_W'($urandom_range(1, 1000));
        end
    endtask

    task automatic test_default_seeds();
        send_bounds('0, '0);
        send_bounds(ALL_ONES, ALL_ONES);
        send_bounds('0, ALL_ONES);
        send_bounds(WORD_W'(41), WORD_W'(42));
        send_bounds(ALL_ONES, '0);
        send_bounds(WORD_W'(1), '0);
        send_bounds(WORD_W'(100), WORD_W'(10));
        send_bounds(-WORD_W'(10), WORD_W'(10));
        send_bounds(SIGN_BIT, ~SIGN_BIT);
        send_bounds('0, SIGN_BIT);
        settle_block();
    endtask

    task automatic test_seed_registers();
        write_reg(CFG_SEED_FIRST, '0);
        write_reg(CFG_SEED_SECOND, '0);
        send_bounds(WORD_W'(7), WORD_W'(1000));
        send_bounds('0, ALL_ONES);
        send_bounds(ALL_ONES, WORD_W'(5));
        settle_block();
        write_reg(CFG_SEED_FIRST, ALL_ONES);
        write_reg(CFG_SEED_SECOND, ALL_ONES);
        send_bounds('0, ALL_ONES);
        send_bounds(ALL_ONES, WORD_W'(3));
        send_bounds(WORD_W'(5), WORD_W'(5));
        settle_block();
        write_reg(CFG_UNUSED_LOW, rand_word());
        write_reg(CFG_UNUSED_HIGH, rand_word());
        send_bounds(rand_word(), rand_word());
        send_bounds('0, WORD_W'(1000));
        settle_block();
        write_reg(CFG_SEED_FIRST, rand_word());
        send_bounds(rand_word(), rand_word());
        send_bounds('0, ALL_ONES);
        settle_block();
    endtask

    task automatic test_back_to_back();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (40) begin
            pick_bounds(lo, hi);
            send_bounds(lo, hi);
        end
        settle_block();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_output_backpressure();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        repeat (16) begin
            pick_bounds(lo, hi);
            send_bounds(lo, hi);
        end
        settle_block();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                write_reg(CFG_SEED_SECOND, '0);
                write_reg(CFG_SEED_FIRST, ALL_ONES);
            end else if ($urandom_range(0, 1) != 0) begin
                write_reg(CFG_SEED_FIRST, rand_word());
                write_reg(CFG_SEED_SECOND, rand_word());
            end else begin
                write_reg(CFG_SEED_SECOND, rand_word());
                write_reg(CFG_SEED_FIRST, rand_word());
            end
            if ($urandom_range(0, 1) != 0) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), rand_word());
            end
            repeat (PHASE_ITEMS) begin
                pick_bounds(lo, hi);
                send_bounds(lo, hi);
            end
            settle_block();
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                stall_left   = hold_off_len - 1;
                hold_off_len = 0;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [WORD_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (value_queue.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = value_queue.pop_front();
                if (m_axis_tdata !== want) begin
                    report_mismatch("value", m_axis_tdata, want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_seeds();
        test_seed_registers();
        test_back_to_back();
        test_output_backpressure();
        test_random_traffic();
        settle_block();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/xrr_pkg.sv
src/xorshift_ranged_random_top.sv
src/xrr_checker.sv
bench/testbench.sv
